// ----- rtl/core/tes_pkg.sv -----
// Package for the timer expiry scheduler: modes, result kinds, sequencer states.
// No dependencies.
`default_nettype none
package tes_pkg;
   localparam int MODE_BITS = 2;
   localparam int SLOT_BITS = 4;
   localparam int DELAY_BITS = 32;
   localparam int OUT_TIME_BITS = 48;
   localparam int KIND_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DEL = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TICK = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_RSVD = 2'd3;

   localparam logic [KIND_BITS-1:0] KIND_ACK = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIRED = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_IDLE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MARK, ST_SCAN, ST_FIRE, ST_EMIT
   } state_type;

   // command from sequencer to every cell
   typedef struct packed {
      logic add;      // write add into selected cell
      logic del;
      logic mark;     // latch due flags
      logic fire;     // winning cell expires / rearms
   } cell_cmd_type;
endpackage
`default_nettype wire

// ----- rtl/core/tes_if.sv -----
// Valid/ready channel interface for the timer expiry scheduler.
// Depends on nothing; payload width set by parameter.
`default_nettype none
interface tes_if #(parameter int W = 8) (input wire logic clock);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/timer_expiry_scheduler.sv -----
// Top level of the timer expiry scheduler: chain of timer cells plus sequencer.
// Depends on tes_pkg, tes_if, tes_cell, tes_seq.
`default_nettype none
// Adds and deletes take one transfer and present their acknowledge in the next
// cycle; the input stays blocked until that acknowledge is taken. A tick latches
// the due flags, then finds each expiry with a running minimum that the cells
// pass one cell per cycle along the chain: the sequencer waits for the minimum to
// reach the chain end, and after slot w fires only the cells from w on must refill
// before the next search. Each expiry adds a fire state and waits on the result
// channel; last is known at fire time from the remaining due flags. An empty tick
// answers with an idle result. One item is in flight at a time.
module timer_expiry_scheduler #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_BITS = 48
) (
   input wire logic clock,
   input wire logic reset,
   tes_if.sink   req,
   tes_if.source rsp
);
   import tes_pkg::*;
   localparam int IB = (NUM_TIMERS > 16) ? $clog2(NUM_TIMERS) : 4;
   logic [1:0] mode; logic [3:0] slot; logic [31:0] delay; logic persist;
   logic [47:0] now48; logic [TIME_BITS-1:0] now;
   assign {mode, slot, delay, persist, now48} = req.data;
   assign now = TIME_BITS'(now48);

   cell_cmd_type cmd;
   logic [IB-1:0] win;
   logic [NUM_TIMERS:0] cv;
   logic [TIME_BITS-1:0] cd [NUM_TIMERS+1];
   logic [IB-1:0] ci [NUM_TIMERS+1];
   logic [NUM_TIMERS-1:0] re_v;
   logic [TIME_BITS-1:0] nd_v [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] due_v, win_hot;
   logic more;
   logic [1:0] kind; logic re, last, rv; logic [47:0] nd;
   logic [3:0] out_slot;
   logic [TIME_BITS-1:0] now_ff;
   logic [IB-1:0] sl;
   assign sl = IB'(slot);
   assign cv[0] = 1'b0; assign cd[0] = '0; assign ci[0] = '0;

   // any timer still due besides the one being fired
   assign win_hot = NUM_TIMERS'(1) << win;
   assign more = |(due_v & ~win_hot);

   always_ff @(posedge clock) if (req.valid && req.ready) now_ff <= now;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      logic sel;
      assign sel = (cmd.add || cmd.del) ? (sl == IB'(g)) : (win == IB'(g));
      tes_cell #(.TIME_BITS(TIME_BITS), .IDX_BITS(IB)) u_cell (
         .clock, .reset, .cmd, .sel,
         .now(cmd.add ? now : now_ff), .delay, .persist, .my_idx(IB'(g)),
         .in_vld(cv[g]), .in_dl(cd[g]), .in_idx(ci[g]),
         .out_vld(cv[g+1]), .out_dl(cd[g+1]), .out_idx(ci[g+1]),
         .re_out(re_v[g]), .nd_out(nd_v[g]), .due_out(due_v[g]));
   end

   tes_seq #(.NUM_TIMERS(NUM_TIMERS), .IDX_BITS(IB), .TIME_BITS(TIME_BITS)) u_seq (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_mode(mode),
      .rsp_valid(rv), .rsp_ready(rsp.ready),
      .chain_vld(cv[NUM_TIMERS]), .chain_idx(ci[NUM_TIMERS]), .more_due(more),
      .win_re(re_v[win]), .win_nd(nd_v[win]),
      .cmd, .win_ff(win), .kind_ff(kind), .slot_ff(out_slot), .re_ff(re), .nd_ff(nd),
      .last_ff(last));

   assign rsp.valid = rv;
   assign rsp.data = {kind, out_slot, re, nd, last};
endmodule
`default_nettype wire

// ----- rtl/core/tes_cell.sv -----
// One timer cell: holds a slot's state and forwards the running minimum.
// Depends on tes_pkg.
`default_nettype none
module tes_cell #(
   parameter int TIME_BITS = 48,
   parameter int IDX_BITS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire tes_pkg::cell_cmd_type cmd,
   input  wire logic sel,                      // this cell is addressed / winner
   input  wire logic [TIME_BITS-1:0] now,
   input  wire logic [31:0] delay,
   input  wire logic persist,
   input  wire logic [IDX_BITS-1:0] my_idx,
   // chain in: best candidate so far
   input  wire logic in_vld,
   input  wire logic [TIME_BITS-1:0] in_dl,
   input  wire logic [IDX_BITS-1:0] in_idx,
   output logic out_vld,
   output logic [TIME_BITS-1:0] out_dl,
   output logic [IDX_BITS-1:0] out_idx,
   output logic re_out,
   output logic [TIME_BITS-1:0] nd_out,
   output logic due_out
);
   import tes_pkg::*;
   localparam logic [TIME_BITS-1:0] TMAX = '1;
   logic pend_ff, pers_ff, due_ff;
   logic [TIME_BITS-1:0] dl_ff;
   logic [31:0] per_ff;
   logic [TIME_BITS:0] s1, s2, sa;
   logic [TIME_BITS-1:0] a1, a2, nd;
   logic mine;
   logic vld_ff;
   logic [TIME_BITS-1:0] best_dl_ff;
   logic [IDX_BITS-1:0] best_idx_ff;

   always_comb begin
      s1 = {1'b0, dl_ff} + {{(TIME_BITS+1-32){1'b0}}, per_ff};
      a1 = s1[TIME_BITS] ? TMAX : s1[TIME_BITS-1:0];
      s2 = {1'b0, now} + {{(TIME_BITS+1-32){1'b0}}, per_ff};
      a2 = s2[TIME_BITS] ? TMAX : s2[TIME_BITS-1:0];
      sa = {1'b0, now} + {{(TIME_BITS+1-32){1'b0}}, delay};
      nd = (a1 < now) ? a2 : a1;
      re_out = pers_ff && (per_ff != '0);
      nd_out = nd;
      // strict less keeps the lower index on ties (chain runs from cell 0)
      mine = due_ff && (!in_vld || dl_ff < in_dl);
   end

   assign out_vld = vld_ff;
   assign out_dl = best_dl_ff;
   assign out_idx = best_idx_ff;
   assign due_out = due_ff;

   // one compare per cell per cycle; the minimum ripples one cell per clock
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld || due_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_dl_ff <= mine ? dl_ff : in_dl;
      best_idx_ff <= mine ? my_idx : in_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         pers_ff <= 1'b0;
         per_ff <= '0;
         due_ff <= 1'b0;
      end else begin
         if (cmd.add && sel) begin
            pend_ff <= 1'b1;
            pers_ff <= persist;
            if (persist) per_ff <= delay;
         end else if (cmd.del && sel) begin
            pend_ff <= 1'b0;
         end else if (cmd.fire && sel) begin
            due_ff <= 1'b0;
            if (!re_out) pend_ff <= 1'b0;
         end
         if (cmd.mark) due_ff <= pend_ff && (dl_ff <= now);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && sel) dl_ff <= sa[TIME_BITS] ? TMAX : sa[TIME_BITS-1:0];
      else if (cmd.fire && sel && re_out) dl_ff <= nd;
   end
endmodule
`default_nettype wire

// ----- rtl/core/tes_seq.sv -----
// Sequencer: accepts requests, steps the cell chain, emits results.
// Depends on tes_pkg.
`default_nettype none
module tes_seq #(
   parameter int NUM_TIMERS = 16,
   parameter int IDX_BITS = 4,
   parameter int TIME_BITS = 48
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [1:0] req_mode,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic chain_vld,
   input  wire logic [IDX_BITS-1:0] chain_idx,
   input  wire logic more_due,
   input  wire logic win_re,
   input  wire logic [TIME_BITS-1:0] win_nd,
   output tes_pkg::cell_cmd_type cmd,
   output logic [IDX_BITS-1:0] win_ff,
   output logic [1:0] kind_ff,
   output logic [tes_pkg::SLOT_BITS-1:0] slot_ff,
   output logic re_ff,
   output logic [47:0] nd_ff,
   output logic last_ff
);
   import tes_pkg::*;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   state_type st_ff, st_in;
   logic [IDX_BITS-1:0] win_in;
   logic [CW-1:0] wait_ff, wait_in;
   logic take, is_ack, idle_done;

   assign take = req_valid && req_ready;
   assign req_ready = (st_ff == ST_IDLE) && !rsp_valid;
   assign is_ack = take && (req_mode inside {MODE_ADD, MODE_DEL});
   assign idle_done = (st_ff == ST_SCAN) && (wait_ff == '0) && !chain_vld;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (take && req_mode == MODE_TICK) st_in = ST_MARK;
         ST_MARK: st_in = ST_SCAN;
         // chain end is settled once the wait count runs out
         ST_SCAN: if (wait_ff == '0) st_in = chain_vld ? ST_FIRE : ST_EMIT;
         ST_FIRE: st_in = ST_EMIT;
         ST_EMIT: if (rsp_ready) st_in = last_ff ? ST_IDLE : ST_SCAN;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      win_in = win_ff;
      wait_in = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;
      case (st_ff)
         ST_IDLE: begin
            cmd.add = take && req_mode == MODE_ADD;
            cmd.del = take && req_mode == MODE_DEL;
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            wait_in = CW'(NUM_TIMERS);
         end
         ST_SCAN: win_in = chain_idx;
         ST_FIRE: begin
            cmd.fire = 1'b1;
            // cells below the winner are unchanged; only the tail must refill
            wait_in = CW'(NUM_TIMERS) - CW'(win_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         wait_ff <= '0;
         win_ff <= '0;
         rsp_valid <= 1'b0;
         kind_ff <= KIND_ACK;
         slot_ff <= '0;
         re_ff <= 1'b0;
         nd_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         wait_ff <= wait_in;
         win_ff <= win_in;
         if (is_ack) begin
            rsp_valid <= 1'b1;
            kind_ff <= KIND_ACK;
            slot_ff <= '0;
            re_ff <= 1'b0;
            nd_ff <= '0;
            last_ff <= 1'b1;
         end else if (idle_done) begin
            rsp_valid <= 1'b1;
            kind_ff <= KIND_IDLE;
            slot_ff <= '0;
            re_ff <= 1'b0;
            nd_ff <= '0;
            last_ff <= 1'b1;
         end else if (st_ff == ST_FIRE) begin
            rsp_valid <= 1'b1;
            kind_ff <= KIND_FIRED;
            slot_ff <= SLOT_BITS'(win_ff);
            re_ff <= win_re;
            nd_ff <= win_re ? 48'(win_nd) : '0;
            last_ff <= !more_due;
         end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for timer_expiry_scheduler: directed and random adds, deletes and ticks,
// checked transfer by transfer against an internal prediction of the timer table.
// Depends on tes_pkg, tes_if and timer_expiry_scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import tes_pkg::*;

   localparam int NT = 16;
   localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [SLOT_BITS-1:0] slot;
      logic [DELAY_BITS-1:0] delay;
      logic persist;
      logic [47:0] now;
   } timer_cmd_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [SLOT_BITS-1:0] fired_slot;
      logic rearmed;
      logic [OUT_TIME_BITS-1:0] next_deadline;
      logic last;
   } timer_evt_type;

   // Shadow timer table; computes the events each accepted command should produce.
   class expiry_board;
      bit pend[NT];
      logic [47:0] dl[NT];
      logic [31:0] per[NT];
      bit pers[NT];
      timer_evt_type due_q[$];
      int errors;

      function new();
         for (int i = 0; i < NT; i++) begin
            pend[i] = 0;
            dl[i] = '0;
            per[i] = '0;
            pers[i] = 0;
         end
         errors = 0;
      endfunction

      function logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
         logic [48:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[48] ? TMAX : s[47:0];
      endfunction

      function void push_evt(logic [1:0] k, int s, bit re, logic [47:0] nd, bit l);
         timer_evt_type e;
         e.kind = k;
         e.fired_slot = s[3:0];
         e.rearmed = re;
         e.next_deadline = nd;
         e.last = l;
         due_q.push_back(e);
      endfunction

      function void note_command(timer_cmd_type c);
         bit due[NT];
         int best;
         int n;
         logic [47:0] nd;
         bit re;
         n = 0;
         if (c.mode == MODE_ADD) begin
            dl[c.slot] = sat_sum(c.now, {16'd0, c.delay});
            pers[c.slot] = c.persist;
            if (c.persist) per[c.slot] = c.delay;
            pend[c.slot] = 1;
            push_evt(KIND_ACK, 0, 0, '0, 1);
         end else if (c.mode == MODE_DEL) begin
            pend[c.slot] = 0;
            push_evt(KIND_ACK, 0, 0, '0, 1);
         end else if (c.mode == MODE_TICK) begin
            for (int i = 0; i < NT; i++) due[i] = pend[i] && dl[i] <= c.now;
            forever begin
               best = -1;
               for (int i = 0; i < NT; i++)
                  if (due[i] && (best < 0 || dl[i] < dl[best])) best = i;
               if (best < 0) break;
               due[best] = 0;
               re = 0;
               nd = '0;
               if (pers[best] && per[best] != 0) begin
                  nd = sat_sum(dl[best], {16'd0, per[best]});
                  if (nd < c.now) nd = sat_sum(c.now, {16'd0, per[best]});
                  dl[best] = nd;
                  re = 1;
               end else begin
                  pend[best] = 0;
               end
               push_evt(KIND_FIRED, best, re, nd, 0);
               n++;
            end
            if (n == 0) push_evt(KIND_IDLE, 0, 0, '0, 1);
            else due_q[$].last = 1;
         end
         // mode 3 is dropped by the block
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("%0t: %s got %0h want %0h", $time, what, got, want);
         errors++;
      endtask

      task check_event(timer_evt_type r);
         timer_evt_type e;
         if (due_q.size() == 0) begin
            report("unexpected transfer", r, 0);
            return;
         end
         e = due_q.pop_front();
         if (r.kind !== e.kind) report("kind", r.kind, e.kind);
         if (r.fired_slot !== e.fired_slot) report("fired_slot", r.fired_slot, e.fired_slot);
         if (r.rearmed !== e.rearmed) report("rearmed", r.rearmed, e.rearmed);
         if (r.next_deadline !== e.next_deadline)
            report("next_deadline", r.next_deadline, e.next_deadline);
         if (r.last !== e.last) report("last", r.last, e.last);
      endtask
   endclass

   logic clock;
   logic reset;
   tes_if #(.W($bits(timer_cmd_type))) req_if (clock);
   tes_if #(.W($bits(timer_evt_type))) rsp_if (clock);

   timer_expiry_scheduler #(.NUM_TIMERS(NT), .TIME_BITS(48)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   expiry_board board = new();
   bit hold_req = 0;
   int cycles = 0;
   logic [47:0] clk_now = 0;
   int burst_left = 0;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("timer_expiry_scheduler: mismatch");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_event(rsp_if.data);

   // Receiver: long hold-off on request, otherwise one of four stall styles chosen at random.
   initial begin
      int phase;
      phase = 0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else begin
            if (cycles % 64 == 0) phase = $urandom_range(0, 3);
            case (phase)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 1) == 0);
               2: rsp_if.ready <= ($urandom_range(0, 4) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 5) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task send(timer_cmd_type c);
      req_if.data <= c;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      board.note_command(c);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   function timer_cmd_type cmd(logic [1:0] m, int s, logic [31:0] d, bit p, logic [47:0] t);
      timer_cmd_type c;
      c.mode = m;
      c.slot = s[3:0];
      c.delay = d;
      c.persist = p;
      c.now = t;
      return c;
   endfunction

   initial begin
      timer_cmd_type c;
      int r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: simple fire, empty tick, sixteen tied adds, a delete, ignored mode
      send(cmd(MODE_ADD, 0, 0, 0, 0));
      send(cmd(MODE_TICK, 0, 0, 0, 0));
      send(cmd(MODE_TICK, 15, 32'hFFFF_FFFF, 1, 0));
      for (int i = 15; i >= 0; i--) send(cmd(MODE_ADD, i, 10, i % 2, 100));
      send(cmd(MODE_DEL, 3, 0, 0, 100));
      send(cmd(MODE_RSVD, 7, 32'hFFFF_FFFF, 1, TMAX));
      send(cmd(MODE_TICK, 0, 0, 0, 110));
      // rearm that falls behind now, period zero persistent, saturation at max time
      send(cmd(MODE_ADD, 5, 32'd0, 1, 200));
      send(cmd(MODE_TICK, 0, 0, 0, 5000));
      send(cmd(MODE_ADD, 9, 32'hFFFF_FFFF, 1, TMAX - 5));
      send(cmd(MODE_TICK, 0, 0, 0, TMAX));
      for (int i = 0; i < NT; i++) send(cmd(MODE_DEL, i, 0, 0, TMAX));
      clk_now = 1000;

      for (int k = 0; k < 220; k++) begin
         if (k == 120) hold_req = 1;
         r = $urandom_range(0, 99);
         if (r < 3) clk_now = {$urandom, $urandom} & TMAX;
         c = cmd(MODE_TICK, $urandom_range(0, 15), $urandom, $urandom_range(0, 1), clk_now);
         if (r < 42) begin
            c.mode = MODE_ADD;
            if ($urandom_range(0, 9) != 0) c.delay = $urandom_range(0, 300);
         end else if (r < 57) begin
            c.mode = MODE_DEL;
         end else if (r < 95) begin
            clk_now = board.sat_sum(clk_now, $urandom_range(0, 250));
            c.now = clk_now;
         end else begin
            c.mode = MODE_RSVD;
         end
         send(c);
      end
      req_if.valid <= 1'b0;

      while (board.due_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.errors == 0)
         $display("timer_expiry_scheduler: match");
      else
         $display("timer_expiry_scheduler: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

// ----- timer_expiry_scheduler.f -----
rtl/core/tes_pkg.sv
rtl/core/tes_if.sv
rtl/core/tes_cell.sv
rtl/core/tes_seq.sv
rtl/core/timer_expiry_scheduler.sv
tb/sv/tb.sv
